>>> rtl/core/ilid_pkg.sv
package ilid_pkg;

	// Beat field widths, fixed by the command and response formats
	localparam int CMD_W    = 2;
	localparam int POS_W    = 9;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Pointer update selected by the controller
	typedef enum logic [2:0] {
		PTR_HOLD      = 3'd0,
		PTR_LOAD_LAST = 3'd1,
		PTR_LOAD_NEXT = 3'd2,
		PTR_DEC       = 3'd3,
		PTR_INC       = 3'd4
	} ptr_op_t;

	// Memory write address and data source
	typedef enum logic [1:0] {
		WR_POS_VALUE = 2'd0,
		WR_PTR_UP    = 2'd1,
		WR_PTR_DOWN  = 2'd2
	} wr_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    set_status;
		status_t status;
		ptr_op_t ptr_op;
		logic    rd_en;
		logic    rd_pos;
		logic    wr_en;
		wr_src_t wr_src;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    load_out;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic pos_bad;
		logic full;
		logic tail;
		logic up_end;
		logic down_end;
	} dp_stat_t;

endpackage

>>> rtl/core/ilid_cmd_if.sv
interface ilid_cmd_if;
	logic                          valid;
	logic                          ready;
	ilid_pkg::cmd_t                cmd;
	logic [ilid_pkg::POS_W-1:0]    pos;
	logic signed [ilid_pkg::VALUE_W-1:0] value;

	modport source (output valid, output cmd, output pos, output value, input ready);
	modport sink (input valid, input cmd, input pos, input value, output ready);
endinterface

>>> rtl/core/ilid_rsp_if.sv
interface ilid_rsp_if;
	logic                                valid;
	logic                                ready;
	ilid_pkg::status_t                   status;
	logic signed [ilid_pkg::VALUE_W-1:0] read_value;
	logic [ilid_pkg::LEN_W-1:0]          length;

	modport source (output valid, output status, output read_value, output length, input ready);
	modport sink (input valid, input status, input read_value, input length, output ready);
endinterface

>>> rtl/core/ilid_ctrl.sv
module ilid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ilid_pkg::dp_stat_t  stat,
	output ilid_pkg::ctl_cmd_t  ctl
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECODE   = 6'b000010,
		S_SHIFT_UP = 6'b000100,
		S_INS_PUT  = 6'b001000,
		S_SHIFT_DN = 6'b010000,
		S_POST     = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Sequence one command through decode, shift and result hand-off
	always_comb begin
		state_d        = state_q;
		ctl.capture    = 1'b0;
		ctl.set_status = 1'b0;
		ctl.status     = ilid_pkg::ST_OK;
		ctl.ptr_op     = ilid_pkg::PTR_HOLD;
		ctl.rd_en      = 1'b0;
		ctl.rd_pos     = 1'b0;
		ctl.wr_en      = 1'b0;
		ctl.wr_src     = ilid_pkg::WR_POS_VALUE;
		ctl.cnt_inc    = 1'b0;
		ctl.cnt_dec    = 1'b0;
		ctl.load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.set_status = 1'b1;
				state_d        = S_POST;
				if (stat.pos_bad) begin
					ctl.status = ilid_pkg::ST_BAD_POS;
				end else begin
					case (stat.cmd)
						ilid_pkg::CMD_INSERT: begin
							if (stat.full) begin
								ctl.status = ilid_pkg::ST_FULL;
							end else if (stat.tail) begin
								ctl.wr_en   = 1'b1;
								ctl.wr_src  = ilid_pkg::WR_POS_VALUE;
								ctl.cnt_inc = 1'b1;
							end else begin
								ctl.ptr_op = ilid_pkg::PTR_LOAD_LAST;
								ctl.rd_en  = 1'b1;
								state_d    = S_SHIFT_UP;
							end
						end
						ilid_pkg::CMD_DELETE: begin
							if (stat.tail) begin
								ctl.cnt_dec = 1'b1;
							end else begin
								ctl.ptr_op = ilid_pkg::PTR_LOAD_NEXT;
								ctl.rd_en  = 1'b1;
								state_d    = S_SHIFT_DN;
							end
						end
						ilid_pkg::CMD_MODIFY: begin
							ctl.wr_en  = 1'b1;
							ctl.wr_src = ilid_pkg::WR_POS_VALUE;
						end
						default: begin
							ctl.rd_en  = 1'b1;
							ctl.rd_pos = 1'b1;
						end
					endcase
				end
			end
			S_SHIFT_UP: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_src = ilid_pkg::WR_PTR_UP;
				if (stat.up_end) begin
					state_d = S_INS_PUT;
				end else begin
					ctl.ptr_op = ilid_pkg::PTR_DEC;
					ctl.rd_en  = 1'b1;
				end
			end
			S_INS_PUT: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_src  = ilid_pkg::WR_POS_VALUE;
				ctl.cnt_inc = 1'b1;
				state_d     = S_POST;
			end
			S_SHIFT_DN: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_src = ilid_pkg::WR_PTR_DOWN;
				if (stat.down_end) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_POST;
				end else begin
					ctl.ptr_op = ilid_pkg::PTR_INC;
					ctl.rd_en  = 1'b1;
				end
			end
			S_POST: begin
				if (slot_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/ilid_dp.sv
module ilid_dp #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ilid_pkg::ctl_cmd_t                    ctl,
	output ilid_pkg::dp_stat_t                    stat,
	input  ilid_pkg::cmd_t                        in_cmd,
	input  logic [ilid_pkg::POS_W-1:0]            in_pos,
	input  logic signed [ilid_pkg::VALUE_W-1:0]   in_value,
	output ilid_pkg::status_t                     out_status,
	output logic signed [ilid_pkg::VALUE_W-1:0]   out_read_value,
	output logic [ilid_pkg::LEN_W-1:0]            out_length
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > ilid_pkg::POS_W) ? CNT_W : ilid_pkg::POS_W;
	localparam int EXT_W  = (ELEM_WIDTH > ilid_pkg::VALUE_W) ? ELEM_WIDTH : ilid_pkg::VALUE_W;

	logic [ELEM_WIDTH-1:0] mem [DEPTH];

	ilid_pkg::cmd_t             cmd_q;
	logic [ilid_pkg::POS_W-1:0] pos_q;
	logic [ilid_pkg::VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]           count_q;
	logic [ADDR_W-1:0]          ptr_q, ptr_d;
	logic [ELEM_WIDTH-1:0]      rdata_q;
	ilid_pkg::status_t          res_status_q;
	ilid_pkg::status_t          out_status_q;
	logic [ilid_pkg::VALUE_W-1:0] out_rd_q;
	logic [ilid_pkg::LEN_W-1:0] out_len_q;

	logic [CMP_W-1:0]      pos_e, cnt_e;
	logic [ADDR_W-1:0]     pos_addr;
	logic [CNT_W-1:0]      cnt_m1;
	logic [ADDR_W-1:0]     rd_addr, wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic [EXT_W-1:0]      val_ext, rd_ext;
	logic [ELEM_WIDTH-1:0] val_elem;
	logic [ilid_pkg::VALUE_W-1:0] rd_word;

	assign pos_e    = CMP_W'(pos_q);
	assign cnt_e    = CMP_W'(count_q);
	assign pos_addr = pos_e[ADDR_W-1:0];
	assign cnt_m1   = count_q - CNT_W'(1);
	assign val_ext  = EXT_W'(value_q);
	assign val_elem = val_ext[ELEM_WIDTH-1:0];
	assign rd_ext   = EXT_W'(rdata_q);
	assign rd_word  = rd_ext[ilid_pkg::VALUE_W-1:0];

	// Report position checks against the current length, the full flag and the shift end flags
	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = (count_q == CNT_W'(DEPTH));
		stat.up_end   = (ptr_q == pos_addr);
		stat.down_end = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
		if (cmd_q == ilid_pkg::CMD_INSERT) begin
			stat.pos_bad = (pos_e > cnt_e);
			stat.tail    = (pos_e == cnt_e);
		end else begin
			stat.pos_bad = (pos_e >= cnt_e);
			stat.tail    = ((pos_e + CMP_W'(1)) == cnt_e);
		end
	end

	// Select the next shift pointer
	always_comb begin
		case (ctl.ptr_op)
			ilid_pkg::PTR_LOAD_LAST: ptr_d = cnt_m1[ADDR_W-1:0];
			ilid_pkg::PTR_LOAD_NEXT: ptr_d = pos_addr + ADDR_W'(1);
			ilid_pkg::PTR_DEC:       ptr_d = ptr_q - ADDR_W'(1);
			ilid_pkg::PTR_INC:       ptr_d = ptr_q + ADDR_W'(1);
			default:                 ptr_d = ptr_q;
		endcase
	end

	assign rd_addr = ctl.rd_pos ? pos_addr : ptr_d;

	// Steer the memory write
	always_comb begin
		case (ctl.wr_src)
			ilid_pkg::WR_PTR_UP: begin
				wr_addr = ptr_q + ADDR_W'(1);
				wr_data = rdata_q;
			end
			ilid_pkg::WR_PTR_DOWN: begin
				wr_addr = ptr_q - ADDR_W'(1);
				wr_data = rdata_q;
			end
			default: begin
				wr_addr = pos_addr;
				wr_data = val_elem;
			end
		endcase
	end

	// Entry store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Capture the command beat, pointer and staged results
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= in_cmd;
			pos_q   <= in_pos;
			value_q <= in_value;
		end
		ptr_q <= ptr_d;
		if (ctl.set_status) begin
			res_status_q <= ctl.status;
		end
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_len_q    <= cnt_e[ilid_pkg::LEN_W-1:0];
			if (cmd_q == ilid_pkg::CMD_READ && res_status_q == ilid_pkg::ST_OK) begin
				out_rd_q <= rd_word;
			end else begin
				out_rd_q <= '0;
			end
		end
	end

	// Track the list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.cnt_dec) begin
			count_q <= cnt_m1;
		end
	end

	assign out_status     = out_status_q;
	assign out_read_value = $signed(out_rd_q);
	assign out_length     = out_len_q;

endmodule

>>> rtl/core/indexed_list_insert_delete.sv
// Position-addressed list of up to DEPTH entries, one command at a time. A command beat on req
// is captured and decoded, and the response register then loads for read, modify, a failed
// command, an insert at the end or a delete of the last entry. An insert at position p into a
// list of n entries first shifts entries p to n - 1 up and then writes the new value at p; a
// delete at p shifts entries p + 1 to n - 1 down. The entry memory moves one entry per cycle
// while later entries shift. After the response loads, the block returns to idle, where it can
// take the next command; the longest command is an insert at the front of a list of DEPTH - 1
// entries. The response stays in its own register until taken on rsp, and the next command may
// be accepted and worked meanwhile; its response waits until the register is free. Entries are not
// cleared at reset; only the length resets to zero, and only written positions are ever read.
module indexed_list_insert_delete #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	ilid_cmd_if.sink   req,
	ilid_rsp_if.source rsp
);

	ilid_pkg::ctl_cmd_t ctl;
	ilid_pkg::dp_stat_t stat;

	ilid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	ilid_dp #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.in_cmd         (req.cmd),
		.in_pos         (req.pos),
		.in_value       (req.value),
		.out_status     (rsp.status),
		.out_read_value (rsp.read_value),
		.out_length     (rsp.length)
	);

`ifndef ASSERT_OFF
	// One command in flight: no beat accepted right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("command accepted while previous one in flight");

	// Failed commands return zero data (non-read commands do too, but only failures are checked)
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ilid_pkg::ST_OK) |-> (rsp.read_value == '0))
		else $error("nonzero read value on failed command");

	// The entry store is written only while a command is being worked
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> !req.ready)
		else $error("entry write while idle");
`endif

endmodule
